>>> rtl/sgc_pkg.sv
// Shared types and constants for the sorted glyph cache.
// Used by the controller, the datapath, the top level and the port checker.
`default_nettype none

package sgc_pkg;

  localparam int KEY_W           = 21;
  localparam int IN_HANDLE_W     = 16;
  localparam int SLOT_W          = 8;
  localparam int IN_TDATA_W      = 40;
  localparam int OUT_TDATA_W     = 32;
  localparam int OUT_PAD_W       = 5;
  localparam int DEF_CACHE_DEPTH = 256;
  localparam int DEF_HANDLE_BITS = 16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_CMP,
    S_DECIDE,
    S_SHIFT,
    S_INSERT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic first_rd;
    logic narrow;
    logic set_hit;
    logic set_fail;
    logic set_full;
    logic set_load;
    logic shift_start;
    logic shift_step;
    logic insert;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic range_empty;
    logic key_eq;
    logic narrow_empty;
    logic load_ok;
    logic full;
    logic no_move;
    logic shift_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/sgc_ctrl.sv
// Controller of the sorted glyph cache: search, insert and result sequencing.
// Depends on sgc_pkg for the state, command and status types.
`default_nettype none

module sgc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire sgc_pkg::stat_t st,
  output sgc_pkg::cmd_t       cmd
);
  import sgc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_FIRST;
        end
      end
      S_FIRST: begin
        if (st.range_empty) begin
          state_nxt = S_DECIDE;
        end else begin
          cmd.first_rd = 1'b1;
          state_nxt    = S_CMP;
        end
      end
      S_CMP: begin
        if (st.key_eq) begin
          cmd.set_hit = 1'b1;
          state_nxt   = S_EMIT;
        end else begin
          cmd.narrow = 1'b1;
          if (st.narrow_empty) begin
            state_nxt = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        priority if (!st.load_ok) begin
          cmd.set_fail = 1'b1;
          state_nxt    = S_EMIT;
        end else if (st.full) begin
          cmd.set_full = 1'b1;
          state_nxt    = S_EMIT;
        end else if (st.no_move) begin
          cmd.set_load = 1'b1;
          state_nxt    = S_INSERT;
        end else begin
          cmd.set_load    = 1'b1;
          cmd.shift_start = 1'b1;
          state_nxt       = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (st.shift_last) begin
          state_nxt = S_INSERT;
        end
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/sgc_dp.sv
// Datapath of the sorted glyph cache: entry memory, search bounds, shift pointer,
// entry count and the output register. Depends on sgc_pkg; driven by sgc_ctrl.
`default_nettype none

module sgc_dp #(
  parameter int CACHE_DEPTH = sgc_pkg::DEF_CACHE_DEPTH,
  parameter int HANDLE_BITS = sgc_pkg::DEF_HANDLE_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [sgc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire sgc_pkg::cmd_t                   cmd,
  output sgc_pkg::stat_t                       st,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [sgc_pkg::OUT_TDATA_W-1:0]      out_tdata
);
  import sgc_pkg::*;

  localparam int AW = $clog2(CACHE_DEPTH);
  localparam int CW = $clog2(CACHE_DEPTH + 1);
  localparam int MW = KEY_W + HANDLE_BITS;

  logic [MW-1:0]          mem [CACHE_DEPTH];
  logic [MW-1:0]          rdata_r;
  logic [KEY_W-1:0]       code_r;
  logic                   ok_r;
  logic [HANDLE_BITS-1:0] hnd_r;
  logic [CW-1:0]          lo_r;
  logic [CW-1:0]          hi_r;
  logic [AW-1:0]          mid_r;
  logic [AW-1:0]          ptr_r;
  logic [CW-1:0]          cnt_r;
  logic                   res_hit_r;
  logic                   res_found_r;
  logic                   res_full_r;
  logic [HANDLE_BITS-1:0] res_hnd_r;
  logic [AW-1:0]          res_slot_r;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [KEY_W-1:0]                   rec_key;
  logic [HANDLE_BITS-1:0]             rec_hnd;
  logic                               key_lt;
  logic [CW:0]                        sum_cur;
  logic [CW:0]                        sum_n;
  logic [AW-1:0]                      mid_cur;
  logic [AW-1:0]                      mid_n;
  logic [CW-1:0]                      lo_n;
  logic [CW-1:0]                      hi_n;
  logic [CW-1:0]                      cnt_m1;
  logic [AW-1:0]                      rd_addr;
  logic [HANDLE_BITS+IN_HANDLE_W-1:0] in_hnd_w;
  logic [HANDLE_BITS+IN_HANDLE_W-1:0] out_hnd_w;
  logic [AW+SLOT_W-1:0]               out_slot_w;

  assign rec_key    = rdata_r[MW-1:HANDLE_BITS];
  assign rec_hnd    = rdata_r[HANDLE_BITS-1:0];
  assign key_lt     = code_r < rec_key;
  assign sum_cur    = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_cur    = sum_cur[AW:1];
  assign lo_n       = key_lt ? lo_r : (CW'(mid_r) + CW'(1));
  assign hi_n       = key_lt ? CW'(mid_r) : hi_r;
  assign sum_n      = {1'b0, lo_n} + {1'b0, hi_n};
  assign mid_n      = sum_n[AW:1];
  assign cnt_m1     = cnt_r - CW'(1);
  assign in_hnd_w   = {{HANDLE_BITS{1'b0}}, in_tdata[KEY_W+1 +: IN_HANDLE_W]};
  assign out_hnd_w  = {{IN_HANDLE_W{1'b0}}, res_hnd_r};
  assign out_slot_w = {{SLOT_W{1'b0}}, res_slot_r};

  always_comb begin
    priority if (cmd.narrow) begin
      rd_addr = mid_n;
    end else if (cmd.first_rd) begin
      rd_addr = mid_cur;
    end else if (cmd.shift_start) begin
      rd_addr = cnt_m1[AW-1:0];
    end else if (cmd.shift_step) begin
      rd_addr = ptr_r - AW'(2);
    end else begin
      rd_addr = mid_r;
    end
  end

  always_comb begin
    st.range_empty  = lo_r == hi_r;
    st.key_eq       = code_r == rec_key;
    st.narrow_empty = lo_n == hi_n;
    st.load_ok      = ok_r;
    st.full         = cnt_r == CW'(CACHE_DEPTH);
    st.no_move      = cnt_r == lo_r;
    st.shift_last   = CW'(ptr_r) == (lo_r + CW'(1));
    st.out_free     = !out_valid_r || out_tready;
  end

  always_ff @(posedge clk) begin
    if (cmd.shift_step) begin
      mem[ptr_r] <= rdata_r;
    end else if (cmd.insert) begin
      mem[lo_r[AW-1:0]] <= {code_r, hnd_r};
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      code_r <= in_tdata[KEY_W-1:0];
      ok_r   <= in_tdata[KEY_W];
      hnd_r  <= in_hnd_w[HANDLE_BITS-1:0];
      lo_r   <= '0;
      hi_r   <= cnt_r;
    end else if (cmd.narrow) begin
      lo_r  <= lo_n;
      hi_r  <= hi_n;
      mid_r <= mid_n;
    end else if (cmd.first_rd) begin
      mid_r <= mid_cur;
    end
    if (cmd.shift_start) begin
      ptr_r <= cnt_r[AW-1:0];
    end else if (cmd.shift_step) begin
      ptr_r <= ptr_r - AW'(1);
    end
    priority if (cmd.set_hit) begin
      res_hit_r   <= 1'b1;
      res_found_r <= 1'b1;
      res_full_r  <= 1'b0;
      res_hnd_r   <= rec_hnd;
      res_slot_r  <= mid_r;
    end else if (cmd.set_fail) begin
      res_hit_r   <= 1'b0;
      res_found_r <= 1'b0;
      res_full_r  <= 1'b0;
      res_hnd_r   <= '0;
      res_slot_r  <= '0;
    end else if (cmd.set_full) begin
      res_hit_r   <= 1'b0;
      res_found_r <= 1'b1;
      res_full_r  <= 1'b1;
      res_hnd_r   <= hnd_r;
      res_slot_r  <= '0;
    end else if (cmd.set_load) begin
      res_hit_r   <= 1'b0;
      res_found_r <= 1'b1;
      res_full_r  <= 1'b0;
      res_hnd_r   <= hnd_r;
      res_slot_r  <= lo_r[AW-1:0];
    end
    if (cmd.emit) begin
      out_data_r <= {{OUT_PAD_W{1'b0}}, res_full_r, out_slot_w[SLOT_W-1:0],
                     out_hnd_w[IN_HANDLE_W-1:0], res_found_r, res_hit_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.insert) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

>>> rtl/sorted_glyph_cache_unit.sv
// Top level of the sorted glyph cache: controller plus datapath.
// Depends on sgc_pkg, sgc_ctrl and sgc_dp.
//
// Usage: one request beat on the in_ stream carries a character code, the
// loader's handle and its success flag. One result beat leaves on the out_
// stream for every request: hit, found, handle, sorted slot and full flag.
// Requests are handled one at a time; in_tready is high only while idle.
// A request occupies the unit until it is back in idle, for a time set by the
// number of probes and, on an insert, by the number of entries moved.
// A binary search makes at most ceil(log2(entries+1)) probes. A miss passes
// through a decision state; an insert further moves each entry above the
// insertion point up one place, one entry per cycle through the entry memory
// (one read port and one write port), and then writes the new entry.
// The result sits in an output register, so a stalled receiver holds it
// there; the next request is taken meanwhile and finishes up to the point of
// loading the output register.
// Reset (rst_n low, synchronous) empties the table and drops any pending
// result; the entry memory is not cleared.
`default_nettype none

module sorted_glyph_cache_unit #(
  parameter int CACHE_DEPTH = sgc_pkg::DEF_CACHE_DEPTH,
  parameter int HANDLE_BITS = sgc_pkg::DEF_HANDLE_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // [20:0] char_code, [21] load_ok, [37:22] load_handle, [39:38] zero
  input  wire logic [sgc_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [0] hit, [1] found, [17:2] glyph_handle, [25:18] slot, [26] table_full
  output logic [sgc_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import sgc_pkg::*;

  cmd_t  cmd;
  stat_t st;

  sgc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  sgc_dp #(
    .CACHE_DEPTH (CACHE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

>>> rtl/sgc_chk.sv
// Port checker for the sorted glyph cache, bound to sorted_glyph_cache_unit.
// Depends on sgc_pkg for the stream widths.
`default_nettype none

module sgc_chk (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [sgc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import sgc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[1] |-> out_tdata[17:2] == 16'd0 && !out_tdata[0]
                                    && !out_tdata[26] && out_tdata[25:18] == 8'd0)
    else $error("not-found result carries data");

  a_hit_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[0] || out_tdata[26]) |-> out_tdata[1]
                                                    && !(out_tdata[0] && out_tdata[26]))
    else $error("hit or full result flags inconsistent");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while one in progress");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind sorted_glyph_cache_unit sgc_chk u_sgc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

>>> bench/glyph_cache_checker.sv
// Port checker for the sorted glyph cache: predicts each result from the request beats.
// Keeps its own sorted code and handle tables and compares every result beat.
// Depends on sgc_pkg.

module glyph_cache_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  // [20:0] char_code, [21] load_ok, [37:22] load_handle, [39:38] zero
  input  logic [sgc_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  // [0] hit, [1] found, [17:2] glyph_handle, [25:18] slot, [26] table_full
  input  logic [sgc_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                             mismatches,
  output int                             pending
);

  localparam int DEPTH = sgc_pkg::DEF_CACHE_DEPTH;

  typedef struct packed {
    logic                            hit;
    logic                            found;
    logic [sgc_pkg::IN_HANDLE_W-1:0] handle;
    logic [sgc_pkg::SLOT_W-1:0]      slot;
    logic                            full;
  } glyph_reply_t;

  logic [sgc_pkg::KEY_W-1:0]       code_tab [DEPTH];
  logic [sgc_pkg::IN_HANDLE_W-1:0] handle_tab [DEPTH];
  int                              cache_fill = 0;
  int                              fail_tally = 0;
  glyph_reply_t                    predicted_replies [$];

  function automatic glyph_reply_t lookup_glyph(input logic [sgc_pkg::KEY_W-1:0] code,
                                                input logic ok,
                                                input logic [sgc_pkg::IN_HANDLE_W-1:0] hdl);
    glyph_reply_t r;
    int           lo;
    int           hi;
    int           mid;
    bit           hit_f;
    r     = '0;
    lo    = 0;
    hi    = cache_fill - 1;
    hit_f = 1'b0;
    while (lo <= hi && !hit_f) begin
      mid = (lo + hi) / 2;
      if (code < code_tab[mid]) begin
        hi = mid - 1;
      end else if (code > code_tab[mid]) begin
        lo = mid + 1;
      end else begin
        hit_f = 1'b1;
        lo    = mid;
      end
    end
    if (hit_f) begin
      r.hit    = 1'b1;
      r.found  = 1'b1;
      r.handle = handle_tab[lo];
      r.slot   = 8'(lo);
    end else if (ok) begin
      r.found  = 1'b1;
      r.handle = hdl;
      if (cache_fill >= DEPTH) begin
        r.full = 1'b1;
      end else begin
        for (int i = cache_fill; i > lo; i--) begin
          code_tab[i]   = code_tab[i-1];
          handle_tab[i] = handle_tab[i-1];
        end
        code_tab[lo]   = code;
        handle_tab[lo] = hdl;
        cache_fill++;
        r.slot = 8'(lo);
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_tally++;
    end
  endtask

  always @(posedge clk) begin : watch_beats
    glyph_reply_t want;
    glyph_reply_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.hit    = out_tdata[0];
        got.found  = out_tdata[1];
        got.handle = out_tdata[17:2];
        got.slot   = out_tdata[25:18];
        got.full   = out_tdata[26];
        if (predicted_replies.size() == 0) begin
          $error("result beat with no request outstanding: %0h", out_tdata);
          fail_tally++;
        end else begin
          want = predicted_replies.pop_front();
          check_field("hit", 32'(want.hit), 32'(got.hit));
          check_field("found", 32'(want.found), 32'(got.found));
          check_field("glyph_handle", 32'(want.handle), 32'(got.handle));
          check_field("slot", 32'(want.slot), 32'(got.slot));
          check_field("table_full", 32'(want.full), 32'(got.full));
        end
      end
      if (in_tvalid && in_tready) begin
        predicted_replies.push_back(lookup_glyph(in_tdata[20:0], in_tdata[21], in_tdata[37:22]));
      end
    end
    mismatches <= fail_tally;
    pending    <= predicted_replies.size();
  end

endmodule

>>> bench/tb_top.sv
// Top of the sorted glyph cache bench: clock, reset, request and result stalls, verdict.
// Depends on sgc_pkg, sorted_glyph_cache_unit and glyph_cache_checker.

module tb_top;

  localparam int MAX_CODE   = 1114111;
  localparam int PHASE_REQS = 150;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [sgc_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [sgc_pkg::OUT_TDATA_W-1:0] out_tdata;
  int                              mismatches;
  int                              pending;
  int                              send_idle;
  int                              recv_idle;
  logic [sgc_pkg::KEY_W-1:0]       seen_codes [$];

  always #2 clk = ~clk;

  sorted_glyph_cache_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  glyph_cache_checker watch (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  task automatic send_request(input logic [sgc_pkg::KEY_W-1:0] code, input logic ok,
                              input logic [sgc_pkg::IN_HANDLE_W-1:0] hdl);
    if ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, hdl, ok, code};
    if (ok) seen_codes.push_back(code);
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_random_burst(input int count);
    int                        roll;
    logic [sgc_pkg::KEY_W-1:0] code;
    logic                      ok;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      ok   = 1'($urandom_range(0, 1));
      if (roll < 62) begin
        code = 21'($urandom_range(0, MAX_CODE));
        ok   = 1'b1;
      end else if (roll < 72) begin
        code = 21'($urandom_range(0, MAX_CODE));
        ok   = 1'b0;
      end else begin
        code = seen_codes[$urandom_range(0, seen_codes.size() - 1)];
        if (roll >= 92) begin
          if (roll[0] && code < MAX_CODE) code = code + 21'd1;
          else if (code > 0) code = code - 21'd1;
        end
      end
      send_request(code, ok, 16'($urandom));
    end
  endtask

  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    send_idle  = 29;
    recv_idle  = 80;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_request(21'd100, 1'b1, 16'hFFFF);
    send_request(21'd100, 1'b0, 16'h0000);
    send_request(21'd50, 1'b0, 16'h1234);
    send_request(21'd50, 1'b1, 16'h0000);
    send_request(21'(MAX_CODE), 1'b1, 16'hA5A5);
    send_request(21'd0, 1'b1, 16'h5A5A);
    send_request(21'd75, 1'b1, 16'h0001);
    send_request(21'(MAX_CODE), 1'b1, 16'h0007);
    send_request(21'd0, 1'b0, 16'hFFFF);
    send_request(21'd101, 1'b0, 16'h8000);
    send_request(21'd99, 1'b1, 16'h8000);
    send_request(21'd100, 1'b1, 16'h0001);
    send_request(21'(MAX_CODE - 1), 1'b1, 16'h7FFF);

    send_random_burst(PHASE_REQS);
    send_idle = 80;
    recv_idle = 29;
    send_random_burst(PHASE_REQS);
    send_idle = 0;
    recv_idle = 0;
    send_random_burst(PHASE_REQS);
    in_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/sgc_pkg.sv
rtl/sgc_ctrl.sv
rtl/sgc_dp.sv
rtl/sorted_glyph_cache_unit.sv
rtl/sgc_chk.sv
bench/glyph_cache_checker.sv
bench/tb_top.sv
